// ===== hw/rtl/apm_pkg.sv =====
// Shared types, constants and arithmetic functions of the audio peak meter.
package apm_pkg;

   localparam int unsigned SampleWidth = 16;
   localparam int unsigned LevelWidth  = 17;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [SampleWidth-1:0] FullScaleU8  = 16'd255;
   localparam logic [SampleWidth-1:0] FullScaleS8  = 16'd127;
   localparam logic [SampleWidth-1:0] FullScaleU16 = 16'd65535;
   localparam logic [SampleWidth-1:0] FullScaleS16 = 16'd32767;
   localparam logic [LevelWidth-1:0]  ThresholdReset = 17'd3277;

   localparam logic [CsrIndexWidth-1:0] CsrWideSamples    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSignedSamples  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrBigEndian      = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrNoiseThreshold = 2'd3;

   typedef struct packed {
      logic                  wide;
      logic                  is_signed;
      logic                  big_endian;
      logic [LevelWidth-1:0] threshold;
   } apm_cfg_type;

   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic [SampleWidth-1:0] magnitude;
   } apm_sample_type;

   function automatic logic [SampleWidth-1:0] apm_magnitude(
      input logic [SampleWidth-1:0] bytes,
      input apm_cfg_type            cfg
   );
      logic [7:0]             b0;
      logic [7:0]             b1;
      logic [SampleWidth-1:0] raw;
      logic [SampleWidth-1:0] result;
      b0 = bytes[7:0];
      b1 = bytes[15:8];
      raw = cfg.big_endian ? {b0, b1} : {b1, b0};
      if (!cfg.wide) begin
         if (cfg.is_signed && b0[7]) begin
            result = {8'd0, 8'(8'd0 - b0)};
         end else begin
            result = {8'd0, b0};
         end
      end else if (cfg.is_signed && raw[15]) begin
         result = SampleWidth'(16'd0 - raw);
      end else begin
         result = raw;
      end
      return result;
   endfunction

   function automatic logic [SampleWidth-1:0] apm_full_scale(input apm_cfg_type cfg);
      logic [SampleWidth-1:0] fs;
      if (cfg.wide) begin
         fs = cfg.is_signed ? FullScaleS16 : FullScaleU16;
      end else begin
         fs = cfg.is_signed ? FullScaleS8 : FullScaleU8;
      end
      return fs;
   endfunction

   // The peak is already clamped to full scale, so each quotient is a scaled
   // copy of the peak plus a small correction found by comparison.
   function automatic logic [LevelWidth-1:0] apm_level(
      input logic [SampleWidth-1:0] pk,
      input apm_cfg_type            cfg
   );
      logic [7:0]            p8;
      logic [6:0]            p7;
      logic [LevelWidth-1:0] lvl;
      p8 = pk[7:0];
      p7 = pk[6:0];
      if (cfg.wide && !cfg.is_signed) begin
         lvl = {1'b0, pk} + LevelWidth'(pk == FullScaleU16);
      end else if (cfg.wide) begin
         lvl = {pk, 1'b0} + LevelWidth'(pk[14]) + LevelWidth'(pk == FullScaleS16);
      end else if (!cfg.is_signed) begin
         lvl = {1'b0, p8, p8} + LevelWidth'(p8 == 8'd255);
      end else begin
         lvl = LevelWidth'({p7, 9'd0}) + LevelWidth'({p7, 2'd0})
             + LevelWidth'(p7 >= 7'd32) + LevelWidth'(p7 >= 7'd64)
             + LevelWidth'(p7 >= 7'd96) + LevelWidth'(p7 == 7'd127);
      end
      return lvl;
   endfunction

endpackage

// ===== hw/rtl/apm_sample_stage.sv =====
// Input register of the peak meter and the decode of each sample to its magnitude.
module apm_sample_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [apm_pkg::SampleWidth-1:0] req_sample_bytes,
   input  logic                            req_last_in_block,
   input  apm_pkg::apm_cfg_type            cfg,
   input  logic                            advance,
   output apm_pkg::apm_sample_type         sample
);
   import apm_pkg::*;

   logic                   valid_ff;
   logic                   valid_in;
   logic                   last_ff;
   logic [SampleWidth-1:0] bytes_ff;
   logic                   accept;

   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bytes_ff <= req_sample_bytes;
         last_ff  <= req_last_in_block;
      end
   end

   always_comb begin
      sample.valid     = valid_ff;
      sample.last      = last_ff;
      sample.magnitude = apm_magnitude(bytes_ff, cfg);
   end

endmodule

// ===== hw/rtl/apm_peak_stage.sv =====
// Running peak, clamp to full scale, level and threshold flag, and the result register.
module apm_peak_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  apm_pkg::apm_sample_type         sample,
   input  apm_pkg::apm_cfg_type            cfg,
   output logic                            advance,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [apm_pkg::SampleWidth-1:0] rsp_peak,
   output logic [apm_pkg::LevelWidth-1:0]  rsp_level,
   output logic                            rsp_above_noise
);
   import apm_pkg::*;

   logic [SampleWidth-1:0] running_peak_ff;
   logic [SampleWidth-1:0] running_peak_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [SampleWidth-1:0] peak_ff;
   logic [LevelWidth-1:0]  level_ff;
   logic                   above_ff;
   logic [SampleWidth-1:0] peak_max;
   logic [SampleWidth-1:0] full_scale;
   logic [SampleWidth-1:0] peak_clamped;
   logic [LevelWidth-1:0]  level_calc;
   logic                   out_free;
   logic                   emit;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = sample.valid && (!sample.last || out_free);
   assign emit     = advance && sample.last;

   assign peak_max = (sample.magnitude > running_peak_ff) ? sample.magnitude : running_peak_ff;
   assign full_scale   = apm_full_scale(cfg);
   assign peak_clamped = (peak_max < full_scale) ? peak_max : full_scale;
   assign level_calc   = apm_level(peak_clamped, cfg);

   always_comb begin
      running_peak_in = running_peak_ff;
      if (advance) begin
         running_peak_in = sample.last ? '0 : peak_max;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_peak_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         running_peak_ff <= running_peak_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         peak_ff  <= peak_clamped;
         level_ff <= level_calc;
         above_ff <= level_calc > cfg.threshold;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_peak        = peak_ff;
   assign rsp_level       = level_ff;
   assign rsp_above_noise = above_ff;

   a_reset_clears_result: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_peak_in_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak <= apm_full_scale(cfg))
      else $error("peak above full scale");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level <= 17'h10000)
      else $error("level above unity");

   a_flag_matches_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_above_noise == (rsp_level > cfg.threshold)))
      else $error("noise flag disagrees with level");

   a_peak_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      emit |=> running_peak_ff == '0)
      else $error("running peak not cleared after last word");

endmodule

// ===== hw/rtl/audio_block_peak_meter_core.sv =====
// Top level of the audio block peak meter: configuration registers and the two stages.
//
// Each req word carries one raw sample (first byte in bits 7:0) and a flag that marks the
// last sample of an analysis block. Samples of every channel are handled alike. The csr
// port writes the format (sample width, signedness, byte order) and the noise threshold;
// the user must write it only while no word is in flight; the block does not enforce this.
// A word passes an input register, where it is decoded to a magnitude, and then updates
// the running peak. A last word also produces one rsp word: the peak clamped to full
// scale, the level as a Q1.16 fraction of full scale and the above-noise flag.
// The rsp word is registered: the last word passes the input register, then the result
// register. Throughput is one req word per cycle unless a last word waits on a pending
// result; the peak update and the result register set that figure.
// Reset returns the registers to 16-bit signed little-endian with a threshold of 3277,
// clears the running peak and drops any pending result.
// When the receiver holds rsp_ready low, non-last words still flow and update the peak;
// a further last word waits in the input register and req_ready falls behind it.
module audio_block_peak_meter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [apm_pkg::SampleWidth-1:0]    req_sample_bytes,
   input  logic                               req_last_in_block,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [apm_pkg::SampleWidth-1:0]    rsp_peak,
   output logic [apm_pkg::LevelWidth-1:0]     rsp_level,
   output logic                               rsp_above_noise,
   input  logic                               csr_write_enable,
   input  logic [apm_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [apm_pkg::LevelWidth-1:0]     csr_wdata
);
   import apm_pkg::*;

   apm_cfg_type    cfg_ff;
   apm_cfg_type    cfg_in;
   apm_sample_type sample;
   logic           advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrWideSamples:    cfg_in.wide       = csr_wdata[0];
            CsrSignedSamples:  cfg_in.is_signed  = csr_wdata[0];
            CsrBigEndian:      cfg_in.big_endian = csr_wdata[0];
            CsrNoiseThreshold: cfg_in.threshold  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wide       <= 1'b1;
         cfg_ff.is_signed  <= 1'b1;
         cfg_ff.big_endian <= 1'b0;
         cfg_ff.threshold  <= ThresholdReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   apm_sample_stage u_sample_stage (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_bytes  (req_sample_bytes),
      .req_last_in_block (req_last_in_block),
      .cfg               (cfg_ff),
      .advance           (advance),
      .sample            (sample)
   );

   apm_peak_stage u_peak_stage (
      .clock           (clock),
      .reset           (reset),
      .sample          (sample),
      .cfg             (cfg_ff),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_peak        (rsp_peak),
      .rsp_level       (rsp_level),
      .rsp_above_noise (rsp_above_noise)
   );

endmodule
